// ===== rtl/gamepad_change_reporter_unit_defines.svh =====
// Assertion macros for the gamepad change reporter.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef GAMEPAD_CHANGE_REPORTER_UNIT_DEFINES_SVH
`define GAMEPAD_CHANGE_REPORTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is low.
`define GCR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("gcr assertion failed");
// Clocked check that also holds during reset.
`define GCR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("gcr assertion failed");
`else
`define GCR_ASSERT(lbl, clk, rst_n, prop)
`define GCR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/gcr_pkg.sv =====
// Shared types, constants and the message packing function of the gamepad
// change reporter. No dependencies.
package gcr_pkg;

    localparam int MSG_LEN  = 13;
    localparam int MSG_BITS = MSG_LEN * 8;
    localparam int CNT_W    = 4;
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MSG_LEN - 1);
    localparam logic [15:0] THRESH_RESET = 16'd2000;

    // one sample, buttons in the low bits (matches the input word layout)
    typedef struct packed {
        logic signed [15:0] ry;
        logic signed [15:0] rx;
        logic signed [15:0] ly;
        logic signed [15:0] lx;
        logic [7:0]         rt;
        logic [7:0]         lt;
        logic [15:0]        buttons;
    } t_sample;

    // byte 0 of the report sits in the low byte; 16-bit fields big-endian
    function automatic logic [MSG_BITS-1:0] build_msg(logic [1:0] idx, t_sample s);
        logic [MSG_BITS-1:0] m;
        m = {s.ry[7:0], s.ry[15:8], s.rx[7:0], s.rx[15:8],
             s.ly[7:0], s.ly[15:8], s.lx[7:0], s.lx[15:8],
             s.rt, s.lt, s.buttons[7:0], s.buttons[15:8], {6'd0, idx}};
        return m;
    endfunction

endpackage

// ===== rtl/gamepad_change_reporter_unit.sv =====
// Top level of the gamepad change reporter: input register, threshold
// register, pad store and report serializer. Depends on gcr_pkg.
//
// Each sample word is taken into an input register and compared combinationally
// against the stored sample of its controller. Samples that are absent, out
// of range or unchanged are dropped without waiting, so such words can enter
// every cycle. A changed sample updates the store and loads a 13-byte report
// into the serializer, which sends one byte per cycle while the receiver is
// ready, with tlast on the thirteenth; the input register waits only while a
// previous report is still being sent, so reports can stream back to back. The
// threshold register resets to 2000 and the store to all zero.
module gamepad_change_reporter_unit #(
    parameter int NUM_PADS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // buttons[15:0], left_trigger[23:16], right_trigger[31:24], left_x[47:32],
    // left_y[63:48], right_x[79:64], right_y[95:80]
    input  logic [95:0] i_s_axis_tdata,
    // pad_index[1:0], present[2]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // msg_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import gcr_pkg::*;

    logic [15:0] r_threshold;
    logic        r_in_valid;
    logic [1:0]  r_idx;
    logic        r_present;
    t_sample     r_sample;

    logic in_range;
    logic changed;
    logic ser_free;
    logic report;
    logic consume;
    logic load;
    logic in_fire;

    assign report  = r_present && in_range && changed;
    assign consume = r_in_valid && (!report || ser_free);
    assign load    = r_in_valid && report && ser_free;
    assign o_s_axis_tready = !r_in_valid || consume;
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx     <= i_s_axis_tuser[1:0];
            r_present <= i_s_axis_tuser[2];
            r_sample  <= t_sample'(i_s_axis_tdata);
        end
    end

    gcr_pad_store #(
        .NUM_PADS (NUM_PADS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_idx      (r_idx),
        .i_sample   (r_sample),
        .i_thresh   (r_threshold),
        .i_we       (load),
        .o_in_range (in_range),
        .o_changed  (changed)
    );

    gcr_msg_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_msg   (build_msg(r_idx, r_sample)),
        .i_ready (i_m_axis_tready),
        .o_free  (ser_free),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// ===== rtl/gcr_pad_store.sv =====
// Per-controller store of the last reported sample and the change detector.
// Depends on gcr_pkg.
module gcr_pad_store #(
    parameter int NUM_PADS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_idx,
    input  gcr_pkg::t_sample i_sample,
    input  logic [15:0]      i_thresh,
    input  logic             i_we,
    output logic             o_in_range,
    output logic             o_changed
);
    import gcr_pkg::*;

    t_sample r_pads [NUM_PADS];
    t_sample stored;

    // |a - b| > thr on a 17-bit difference, so no overflow
    function automatic logic axis_moved(logic [15:0] a, logic [15:0] b, logic [15:0] thr);
        logic [16:0] d;
        logic [16:0] mag;
        d   = {a[15], a} - {b[15], b};
        mag = d[16] ? (~d + 17'd1) : d;
        return mag > {1'b0, thr};
    endfunction

    always_comb begin
        stored     = '0;
        o_in_range = 1'b0;
        for (int k = 0; k < NUM_PADS; k++) begin
            if (int'(i_idx) == k) begin
                stored     = r_pads[k];
                o_in_range = 1'b1;
            end
        end
    end

    assign o_changed = (stored.buttons != i_sample.buttons) ||
                       (stored.lt != i_sample.lt) || (stored.rt != i_sample.rt) ||
                       axis_moved(stored.lx, i_sample.lx, i_thresh) ||
                       axis_moved(stored.ly, i_sample.ly, i_thresh) ||
                       axis_moved(stored.rx, i_sample.rx, i_thresh) ||
                       axis_moved(stored.ry, i_sample.ry, i_thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PADS; k++) begin
                r_pads[k] <= '0;
            end
        end else if (i_we) begin
            for (int k = 0; k < NUM_PADS; k++) begin
                if (int'(i_idx) == k) begin
                    r_pads[k] <= i_sample;
                end
            end
        end
    end

endmodule

// ===== rtl/gcr_msg_ser.sv =====
// Report serializer: holds one 13-byte message and sends it a byte per cycle while i_ready is high.
// Depends on gcr_pkg and the assertion macro header.
`include "gamepad_change_reporter_unit_defines.svh"

module gcr_msg_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [gcr_pkg::MSG_BITS-1:0] i_msg,
    input  logic                         i_ready,
    output logic                         o_free,
    output logic                         o_valid,
    output logic [7:0]                   o_data,
    output logic                         o_last
);
    import gcr_pkg::*;

    logic                r_valid;
    logic [CNT_W-1:0]    r_cnt;
    logic [MSG_BITS-1:0] r_buf;
    logic                at_last;

    assign at_last = (r_cnt == LAST_IDX);
    // free now, or the last word leaves at this edge
    assign o_free  = !r_valid || (i_ready && at_last);
    assign o_valid = r_valid;
    assign o_data  = r_buf[7:0];
    assign o_last  = at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (r_valid && i_ready) begin
            if (at_last) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_msg;
        end else if (r_valid && i_ready) begin
            r_buf <= r_buf >> 8;
        end
    end

    `GCR_ASSERT(a_cnt_range, i_clk, i_rst_n, r_valid |-> (r_cnt <= LAST_IDX))
    `GCR_ASSERT(a_load_free, i_clk, i_rst_n, i_load |-> o_free)
    `GCR_ASSERT(a_no_gap, i_clk, i_rst_n, (r_valid && i_ready && !at_last) |=> r_valid)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for gamepad_change_reporter_unit: random and directed pad samples,
// per-pad change prediction and byte-by-byte check of the 13-byte reports.
// Depends on gcr_pkg and the RTL top level.
import gcr_pkg::*;

typedef struct {
    logic [7:0] data;
    logic       last;
} t_report_byte;

class pad_report_board;
    int          pad_count;
    t_sample     stored_pad[];
    logic [15:0] threshold;
    t_report_byte expected_bytes[$];
    int          errors;

    function new(int pads);
        pad_count = pads;
        stored_pad = new[pads];
        foreach (stored_pad[i]) stored_pad[i] = '0;
        threshold = THRESH_RESET;
        errors = 0;
    endfunction

    function void set_threshold(logic [15:0] v);
        threshold = v;
    endfunction

    function int unsigned axis_gap(logic signed [15:0] a, logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function void push_byte(logic [7:0] data, logic last);
        t_report_byte rb;
        rb.data = data;
        rb.last = last;
        expected_bytes.push_back(rb);
    endfunction

    // accepted input word: decide whether it reports, update store, queue bytes
    function void note_sample(logic [1:0] idx, logic present, t_sample s);
        t_sample p;
        logic    changed;
        if (!present || idx >= pad_count) return;
        p = stored_pad[idx];
        changed = (p.buttons != s.buttons) || (p.lt != s.lt) || (p.rt != s.rt);
        if (axis_gap(p.lx, s.lx) > threshold) changed = 1'b1;
        if (axis_gap(p.ly, s.ly) > threshold) changed = 1'b1;
        if (axis_gap(p.rx, s.rx) > threshold) changed = 1'b1;
        if (axis_gap(p.ry, s.ry) > threshold) changed = 1'b1;
        if (!changed) return;
        stored_pad[idx] = s;
        push_byte({6'd0, idx}, 1'b0);
        push_byte(s.buttons[15:8], 1'b0);
        push_byte(s.buttons[7:0], 1'b0);
        push_byte(s.lt, 1'b0);
        push_byte(s.rt, 1'b0);
        push_byte(s.lx[15:8], 1'b0);
        push_byte(s.lx[7:0], 1'b0);
        push_byte(s.ly[15:8], 1'b0);
        push_byte(s.ly[7:0], 1'b0);
        push_byte(s.rx[15:8], 1'b0);
        push_byte(s.rx[7:0], 1'b0);
        push_byte(s.ry[15:8], 1'b0);
        push_byte(s.ry[7:0], 1'b1);
    endfunction

    task report(string what);
        errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_byte(logic [7:0] data, logic last);
        t_report_byte rb;
        if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected word data=%h last=%b", data, last));
        end else begin
            rb = expected_bytes.pop_front();
            if (data !== rb.data)
                report($sformatf("data %h, expected %h", data, rb.data));
            if (last !== rb.last)
                report($sformatf("last %b, expected %b (data %h)", last, rb.last, data));
        end
    endtask
endclass

module tb_top;
    localparam int PAD_COUNT = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [95:0] i_s_axis_tdata;    // buttons, lt, rt, lx, ly, rx, ry
    logic [2:0]  i_s_axis_tuser;    // pad_index[1:0], present[2]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;    // msg_byte[7:0]
    logic        o_m_axis_tlast;

    logic        no_idle = 1'b0;
    int          quiet_cycles = 0;
    pad_report_board board = new(PAD_COUNT);

    gamepad_change_reporter_unit #(.NUM_PADS(PAD_COUNT)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // monitors: both sides sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                board.note_sample(i_s_axis_tuser[1:0], i_s_axis_tuser[2],
                                  t_sample'(i_s_axis_tdata));
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_byte(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver back-pressure in random bursts
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!no_idle && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    function automatic t_sample make_sample(logic [15:0] buttons, logic [7:0] lt,
                                            logic [7:0] rt, logic [15:0] lx,
                                            logic [15:0] ly, logic [15:0] rx,
                                            logic [15:0] ry);
        t_sample s;
        s.buttons = buttons;
        s.lt = lt;
        s.rt = rt;
        s.lx = lx;
        s.ly = ly;
        s.rx = rx;
        s.ry = ry;
        return s;
    endfunction

    task send_word(logic [1:0] idx, logic present, t_sample s);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tuser  <= {present, idx};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task pad(logic [1:0] idx, logic present, logic [15:0] buttons, logic [7:0] lt,
             logic [7:0] rt, logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
             logic [15:0] ry);
        send_word(idx, present, make_sample(buttons, lt, rt, lx, ly, rx, ry));
    endtask

    // stop sending, let every report drain, then cover a word still in compare
    task settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_threshold(logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_threshold(v);
    endtask

    // mostly variations of the stored sample so changes land near the edges
    task random_word();
        logic [1:0]  idx;
        logic        present;
        t_sample     s;
        logic [15:0] d;
        logic [15:0] step;
        int unsigned thr;
        int unsigned mode;
        idx = 2'($urandom_range(0, PAD_COUNT - 1));
        present = 1'b1;
        s = board.stored_pad[idx];
        thr = board.threshold;
        mode = $urandom_range(0, 99);
        if (mode < 10) begin
            present = 1'b0;
            s = {$urandom, $urandom, $urandom};
        end else if (mode < 22) begin
            // repeat of the stored sample
        end else if (mode < 55) begin
            case ($urandom_range(0, 3))
                0: d = 16'(thr);
                1: d = 16'(thr + 1);
                2: d = (thr == 0) ? 16'd0 : 16'(thr - 1);
                default: d = 16'($urandom_range(0, thr));
            endcase
            step = $urandom_range(0, 1) ? -d : d;
            case ($urandom_range(0, 3))
                0: s.lx = s.lx + step;
                1: s.ly = s.ly + step;
                2: s.rx = s.rx + step;
                default: s.ry = s.ry + step;
            endcase
        end else if (mode < 75) begin
            case ($urandom_range(0, 2))
                0: s.buttons[4'($urandom_range(0, 15))] ^= 1'b1;
                1: s.lt = 8'($urandom);
                default: s.rt = 8'($urandom);
            endcase
        end else begin
            s = {$urandom, $urandom, $urandom};
        end
        send_word(idx, present, s);
    endtask

    initial begin
        logic [15:0] phase_thr[5];
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold 2000
        pad(0, 0, 16'hFFFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h1234);
        pad(0, 1, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pad(0, 1, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pad(0, 1, 16'hFFFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pad(1, 1, 16'h0000, 8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pad(2, 1, 16'h0000, 8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pad(3, 1, 16'h8001, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // axis exactly at threshold, then one past it
        pad(0, 1, 16'hFFFF, 8'h00, 8'h00, 16'd2000, 16'h0000, 16'h0000, 16'h0000);
        pad(0, 1, 16'hFFFF, 8'h00, 8'h00, 16'd2001, 16'h0000, 16'h0000, 16'h0000);
        pad(0, 1, 16'hFFFF, 8'h00, 8'h00, 16'd1, 16'h0000, 16'h0000, 16'h0000);
        pad(0, 1, 16'hFFFF, 8'h00, 8'h00, 16'd1, -16'sd2001, 16'h0000, 16'h0000);
        // full-scale swings
        pad(1, 1, 16'h0000, 8'hFF, 8'h00, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        pad(1, 1, 16'h0000, 8'hFF, 8'h00, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        pad(1, 1, 16'h0000, 8'hFF, 8'h00, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        pad(2, 1, 16'h0000, 8'h00, 8'hFF, 16'h0000, 16'h0000, -16'sd2001, 16'd2001);
        settle();

        // max threshold: no axis swing can count
        write_threshold(16'hFFFF);
        pad(1, 1, 16'h0000, 8'hFF, 8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        pad(1, 1, 16'h0000, 8'hFE, 8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        settle();

        // zero threshold: any axis step counts
        write_threshold(16'h0000);
        pad(1, 1, 16'h0000, 8'hFE, 8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        pad(1, 1, 16'h0000, 8'hFE, 8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFE);
        pad(3, 1, 16'h8001, 8'h00, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        pad(3, 1, 16'h8001, 8'h00, 8'h01, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        settle();

        phase_thr[0] = THRESH_RESET;
        phase_thr[1] = 16'h0000;
        phase_thr[2] = 16'hFFFF;
        phase_thr[3] = 16'($urandom_range(0, 65535));
        phase_thr[4] = 16'($urandom_range(1, 64));
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) no_idle = 1'b1;
            write_threshold(phase_thr[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) random_word();
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.expected_bytes.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
